// ===== rtl/core/swcl_pkg.sv =====
// swcl_pkg: types, constants and rounding helpers for the swing cone limit evaluator
// no dependencies; used by the channel interfaces and the top level
package swcl_pkg;

  localparam int DW       = 16;
  localparam int UW       = DW - 1;
  localparam int ONE_Q14  = 16384;
  localparam int PI_Q13   = 25736;
  localparam int BIAS_LIM = 25736;
  localparam int AC0      = 102940;
  localparam int AC1      = -13901;
  localparam int AC2      = 4867;
  localparam int AC3      = -1227;
  localparam int REG_IW   = 3;

  localparam logic [REG_IW-1:0] REG_AX   = 3'd0;
  localparam logic [REG_IW-1:0] REG_AY   = 3'd1;
  localparam logic [REG_IW-1:0] REG_AZ   = 3'd2;
  localparam logic [REG_IW-1:0] REG_BX   = 3'd3;
  localparam logic [REG_IW-1:0] REG_BY   = 3'd4;
  localparam logic [REG_IW-1:0] REG_BZ   = 3'd5;
  localparam logic [REG_IW-1:0] REG_MAX  = 3'd6;
  localparam logic [REG_IW-1:0] REG_GAIN = 3'd7;

  typedef logic signed [63:0] s64_t;

  typedef struct packed {
    logic signed [DW-1:0] orient_a_w;
    logic signed [DW-1:0] orient_a_x;
    logic signed [DW-1:0] orient_a_y;
    logic signed [DW-1:0] orient_a_z;
    logic signed [DW-1:0] orient_b_w;
    logic signed [DW-1:0] orient_b_x;
    logic signed [DW-1:0] orient_b_y;
    logic signed [DW-1:0] orient_b_z;
  } swcl_in_t;

  typedef struct packed {
    logic signed [DW-1:0] hinge_x;
    logic signed [DW-1:0] hinge_y;
    logic signed [DW-1:0] hinge_z;
    logic [UW-1:0]        swing_angle;
    logic signed [DW-1:0] velocity_bias;
    logic                 limit_active;
  } swcl_out_t;

  // right shift rounding half away from zero
  function automatic s64_t rnd_sh(input s64_t v, input int s);
    logic [63:0] mag;
    logic [63:0] half;
    logic [63:0] q;
    half = 64'd1 << (s - 1);
    mag  = v[63] ? 64'(-v) : 64'(v);
    q    = (mag + half) >> s;
    return v[63] ? -$signed(q) : $signed(q);
  endfunction

  function automatic s64_t clamp(input s64_t v, input s64_t lo, input s64_t hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

endpackage

// ===== rtl/core/swcl_ifs.sv =====
// swcl channel interfaces: input items, result items and register writes
// depends on swcl_pkg for the payload types
interface swcl_in_if;
  import swcl_pkg::*;
  logic     valid;
  logic     ready;
  swcl_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface swcl_out_if;
  import swcl_pkg::*;
  logic      valid;
  logic      ready;
  swcl_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface swcl_cfg_if;
  import swcl_pkg::*;
  logic              valid;
  logic              ready;
  logic [REG_IW-1:0] index;
  logic [DW-1:0]     data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/ik_swing_cone_limit_eval_top.sv =====
// swing cone limit evaluator: a fourteen-stage pipeline, one item per cycle unless out_ch stalls
// depends on swcl_pkg and the channel interfaces in swcl_ifs.sv
//
// in_ch carries two bone orientation quaternions (Q2.14) per item. out_ch
// returns the hinge axis (cross of the two world axes), the swing angle in
// Q2.13, the velocity bias and the limit flag. cfg_ch writes the eight
// registers (two local axes, max angle, error gain); it is always ready. The user
// must write it only while no item is in flight; the block does not enforce this.
// The result passes through 14 register stages on its way to out_ch.
// Throughput is one item per cycle while out_ch is not stalled: rotation
// (2 stages of multiplies plus a rounding stage), dot/cross (2), arccosine
// with a 15-step square root done three steps per stage over 5 stages,
// then polynomial product, angle, gain product and bias (4). The last stage
// is the output register.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_ch.ready drops; bubbles inside the pipeline are not squeezed out.
// Reset clears all valid bits and loads the register defaults: both axes
// (1,0,0), max angle 0, gain 1.0.
module ik_swing_cone_limit_eval_top (
  input  logic              clk,
  input  logic              rst_n,
  swcl_in_if.sink           in_ch,
  swcl_out_if.source        out_ch,
  swcl_cfg_if.sink          cfg_ch
);
  import swcl_pkg::*;

  localparam int NSTG = 14;
  localparam int NAC  = 5;

  // configuration
  logic signed [DW-1:0] axis_r [2][3];
  logic [UW-1:0]        max_angle_r;
  logic [UW-1:0]        gain_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_r[0][0] <= DW'(ONE_Q14);
      axis_r[0][1] <= '0;
      axis_r[0][2] <= '0;
      axis_r[1][0] <= DW'(ONE_Q14);
      axis_r[1][1] <= '0;
      axis_r[1][2] <= '0;
      max_angle_r  <= '0;
      gain_r       <= UW'(ONE_Q14);
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_AX:   axis_r[0][0] <= cfg_ch.data;
        REG_AY:   axis_r[0][1] <= cfg_ch.data;
        REG_AZ:   axis_r[0][2] <= cfg_ch.data;
        REG_BX:   axis_r[1][0] <= cfg_ch.data;
        REG_BY:   axis_r[1][1] <= cfg_ch.data;
        REG_BZ:   axis_r[1][2] <= cfg_ch.data;
        REG_MAX:  max_angle_r  <= cfg_ch.data[UW-1:0];
        REG_GAIN: gain_r       <= cfg_ch.data[UW-1:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic [NSTG-1:0] vld_r;
  logic            en;

  assign en          = !vld_r[NSTG-1] || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NSTG-2:0], in_ch.valid};
    end
  end

  // stage 1: c = q x v
  logic signed [DW-1:0] qin [2][4];
  logic signed [DW-1:0] s1_q_r [2][4];
  logic signed [DW-1:0] s1_v_r [2][3];
  logic signed [32:0]   s1_c_r [2][3];
  logic signed [32:0]   s1_c_nxt [2][3];
  s64_t                 t1_a, t1_b, t1_c;

  assign qin[0][0] = in_ch.data.orient_a_w;
  assign qin[0][1] = in_ch.data.orient_a_x;
  assign qin[0][2] = in_ch.data.orient_a_y;
  assign qin[0][3] = in_ch.data.orient_a_z;
  assign qin[1][0] = in_ch.data.orient_b_w;
  assign qin[1][1] = in_ch.data.orient_b_x;
  assign qin[1][2] = in_ch.data.orient_b_y;
  assign qin[1][3] = in_ch.data.orient_b_z;

  always_comb begin
    for (int b = 0; b < 2; b++) begin
      t1_a = s64_t'(qin[b][2]) * s64_t'(axis_r[b][2]) - s64_t'(qin[b][3]) * s64_t'(axis_r[b][1]);
      t1_b = s64_t'(qin[b][3]) * s64_t'(axis_r[b][0]) - s64_t'(qin[b][1]) * s64_t'(axis_r[b][2]);
      t1_c = s64_t'(qin[b][1]) * s64_t'(axis_r[b][1]) - s64_t'(qin[b][2]) * s64_t'(axis_r[b][0]);
      s1_c_nxt[b][0] = t1_a[32:0];
      s1_c_nxt[b][1] = t1_b[32:0];
      s1_c_nxt[b][2] = t1_c[32:0];
    end
  end

  // stage 2: u = q x t, w*t with t = 2c
  logic signed [DW-1:0] s2_v_r [2][3];
  logic signed [50:0]   s2_wt_r [2][3];
  logic signed [50:0]   s2_u_r [2][3];
  logic signed [50:0]   s2_wt_nxt [2][3];
  logic signed [50:0]   s2_u_nxt [2][3];
  s64_t                 t2 [3];
  s64_t                 t2_u [3];
  s64_t                 t2_w;

  always_comb begin
    for (int b = 0; b < 2; b++) begin
      for (int i = 0; i < 3; i++) begin
        t2[i] = s64_t'(s1_c_r[b][i]) <<< 1;
      end
      t2_u[0] = s64_t'(s1_q_r[b][2]) * t2[2] - s64_t'(s1_q_r[b][3]) * t2[1];
      t2_u[1] = s64_t'(s1_q_r[b][3]) * t2[0] - s64_t'(s1_q_r[b][1]) * t2[2];
      t2_u[2] = s64_t'(s1_q_r[b][1]) * t2[1] - s64_t'(s1_q_r[b][2]) * t2[0];
      for (int i = 0; i < 3; i++) begin
        t2_w = s64_t'(s1_q_r[b][0]) * t2[i];
        s2_wt_nxt[b][i] = t2_w[50:0];
        s2_u_nxt[b][i]  = t2_u[i][50:0];
      end
    end
  end

  // stage 3: world axes, rounded and saturated
  logic signed [DW-1:0] s3_w_r [2][3];
  logic signed [DW-1:0] s3_w_nxt [2][3];
  s64_t                 t3;

  always_comb begin
    for (int b = 0; b < 2; b++) begin
      for (int i = 0; i < 3; i++) begin
        t3 = (s64_t'(s2_v_r[b][i]) <<< 28) + s64_t'(s2_wt_r[b][i]) + s64_t'(s2_u_r[b][i]);
        t3 = clamp(rnd_sh(t3, 28), -s64_t'(ONE_Q14), s64_t'(ONE_Q14));
        s3_w_nxt[b][i] = t3[DW-1:0];
      end
    end
  end

  // stage 4: dot and cross partial products
  logic signed [31:0] s4_d_r [3];
  logic signed [31:0] s4_x_r [6];
  logic signed [31:0] s4_d_nxt [3];
  logic signed [31:0] s4_x_nxt [6];
  s64_t               t4;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      t4 = s64_t'(s3_w_r[0][i]) * s64_t'(s3_w_r[1][i]);
      s4_d_nxt[i] = t4[31:0];
    end
    // cross terms: h[i] = x[2i] - x[2i+1]
    t4 = s64_t'(s3_w_r[0][1]) * s64_t'(s3_w_r[1][2]); s4_x_nxt[0] = t4[31:0];
    t4 = s64_t'(s3_w_r[0][2]) * s64_t'(s3_w_r[1][1]); s4_x_nxt[1] = t4[31:0];
    t4 = s64_t'(s3_w_r[0][2]) * s64_t'(s3_w_r[1][0]); s4_x_nxt[2] = t4[31:0];
    t4 = s64_t'(s3_w_r[0][0]) * s64_t'(s3_w_r[1][2]); s4_x_nxt[3] = t4[31:0];
    t4 = s64_t'(s3_w_r[0][0]) * s64_t'(s3_w_r[1][1]); s4_x_nxt[4] = t4[31:0];
    t4 = s64_t'(s3_w_r[0][1]) * s64_t'(s3_w_r[1][0]); s4_x_nxt[5] = t4[31:0];
  end

  // stage 5: dot and hinge
  logic signed [DW-1:0] s5_dot_r;
  logic signed [DW-1:0] s5_h_r [3];
  logic signed [DW-1:0] s5_dot_nxt;
  logic signed [DW-1:0] s5_h_nxt [3];
  s64_t                 t5;

  always_comb begin
    t5 = s64_t'(s4_d_r[0]) + s64_t'(s4_d_r[1]) + s64_t'(s4_d_r[2]);
    t5 = clamp(rnd_sh(t5, 14), -s64_t'(ONE_Q14), s64_t'(ONE_Q14));
    s5_dot_nxt = t5[DW-1:0];
    for (int i = 0; i < 3; i++) begin
      t5 = s64_t'(s4_x_r[2*i]) - s64_t'(s4_x_r[2*i+1]);
      t5 = clamp(rnd_sh(t5, 14), -s64_t'(ONE_Q14), s64_t'(ONE_Q14));
      s5_h_nxt[i] = t5[DW-1:0];
    end
  end

  // arccosine: square root three steps per stage, Horner in the first three
  logic [28:0]          ac_n_r [NAC];
  logic [29:0]          ac_rt_r [NAC];
  logic signed [19:0]   ac_p_r [NAC];
  logic [14:0]          ac_x_r [NAC];
  logic                 ac_neg_r [NAC];
  logic signed [DW-1:0] ac_h_r [NAC][3];

  logic [28:0]          ac_n_nxt [NAC];
  logic [29:0]          ac_rt_nxt [NAC];
  logic signed [19:0]   ac_p_nxt [NAC];
  logic [28:0]          src_n [NAC];
  logic [29:0]          src_rt [NAC];
  logic signed [19:0]   src_p [NAC];
  logic [14:0]          src_x [NAC];
  logic [14:0]          ent_x;
  logic [29:0]          bitv;
  logic [29:0]          trial;
  s64_t                 t6;
  s64_t                 coef;

  always_comb begin
    ent_x  = s5_dot_r[DW-1] ? 15'(-s5_dot_r) : s5_dot_r[14:0];
    src_n[0]  = 29'((16'(ONE_Q14) - {1'b0, ent_x}) ) << 14;
    src_rt[0] = '0;
    src_p[0]  = 20'(AC3);
    src_x[0]  = ent_x;
    for (int k = 1; k < NAC; k++) begin
      src_n[k]  = ac_n_r[k-1];
      src_rt[k] = ac_rt_r[k-1];
      src_p[k]  = ac_p_r[k-1];
      src_x[k]  = ac_x_r[k-1];
    end
    for (int k = 0; k < NAC; k++) begin
      ac_n_nxt[k]  = src_n[k];
      ac_rt_nxt[k] = src_rt[k];
      for (int i = 0; i < 3; i++) begin
        bitv  = 30'd1 << (28 - 2 * (3 * k + i));
        trial = ac_rt_nxt[k] + bitv;
        if ({1'b0, ac_n_nxt[k]} >= trial) begin
          ac_n_nxt[k]  = ac_n_nxt[k] - trial[28:0];
          ac_rt_nxt[k] = (ac_rt_nxt[k] >> 1) + bitv;
        end else begin
          ac_rt_nxt[k] = ac_rt_nxt[k] >> 1;
        end
      end
      coef = (k == 0) ? s64_t'(AC2) : ((k == 1) ? s64_t'(AC1) : s64_t'(AC0));
      t6 = coef + rnd_sh(s64_t'(src_p[k]) * s64_t'({1'b0, src_x[k]}), 14);
      ac_p_nxt[k] = (k < 3) ? t6[19:0] : src_p[k];
    end
  end

  // stage 11: polynomial times root
  logic signed [35:0]   s7_prod_r;
  logic                 s7_neg_r;
  logic signed [DW-1:0] s7_h_r [3];
  logic signed [35:0]   s7_prod_nxt;
  s64_t                 t7;

  always_comb begin
    t7 = s64_t'(ac_p_r[NAC-1]) * s64_t'({1'b0, ac_rt_r[NAC-1][14:0]});
    s7_prod_nxt = t7[35:0];
  end

  // stage 12: angle, limit test and slack
  logic [UW-1:0]        s8_angle_r;
  logic                 s8_act_r;
  logic signed [16:0]   s8_diff_r;
  logic signed [DW-1:0] s8_h_r [3];
  logic [UW-1:0]        s8_angle_nxt;
  logic signed [16:0]   s8_diff_nxt;
  s64_t                 t8;

  always_comb begin
    t8 = rnd_sh(rnd_sh(s64_t'(s7_prod_r), 14), 3);
    if (s7_neg_r) begin
      t8 = s64_t'(PI_Q13) - t8;
    end
    t8 = clamp(t8, 64'sd0, s64_t'(PI_Q13));
    s8_angle_nxt = t8[UW-1:0];
    s8_diff_nxt  = $signed({2'b00, s8_angle_nxt}) - $signed({2'b00, max_angle_r});
  end

  // stage 13: gain product
  logic signed [32:0]   s9_gm_r;
  logic [UW-1:0]        s9_angle_r;
  logic                 s9_act_r;
  logic signed [16:0]   s9_diff_r;
  logic signed [DW-1:0] s9_h_r [3];
  logic signed [32:0]   s9_gm_nxt;
  s64_t                 t9;

  always_comb begin
    t9 = s64_t'($signed({1'b0, gain_r})) * s64_t'(s8_diff_r);
    s9_gm_nxt = t9[32:0];
  end

  // stage 14: bias, output register
  swcl_out_t out_r;
  swcl_out_t out_nxt;
  s64_t      t10;

  always_comb begin
    t10 = s9_act_r ? rnd_sh(s64_t'(s9_gm_r), 14) : s64_t'(s9_diff_r);
    t10 = clamp(t10, -s64_t'(BIAS_LIM), s64_t'(BIAS_LIM));
    out_nxt.hinge_x       = s9_h_r[0];
    out_nxt.hinge_y       = s9_h_r[1];
    out_nxt.hinge_z       = s9_h_r[2];
    out_nxt.swing_angle   = s9_angle_r;
    out_nxt.velocity_bias = t10[DW-1:0];
    out_nxt.limit_active  = s9_act_r;
  end

  // payload registers, all stages move together
  always_ff @(posedge clk) begin
    if (en) begin
      for (int b = 0; b < 2; b++) begin
        for (int i = 0; i < 4; i++) begin
          s1_q_r[b][i] <= qin[b][i];
        end
        for (int i = 0; i < 3; i++) begin
          s1_v_r[b][i]  <= axis_r[b][i];
          s1_c_r[b][i]  <= s1_c_nxt[b][i];
          s2_v_r[b][i]  <= s1_v_r[b][i];
          s2_wt_r[b][i] <= s2_wt_nxt[b][i];
          s2_u_r[b][i]  <= s2_u_nxt[b][i];
          s3_w_r[b][i]  <= s3_w_nxt[b][i];
        end
      end
      for (int i = 0; i < 3; i++) begin
        s4_d_r[i] <= s4_d_nxt[i];
      end
      for (int i = 0; i < 6; i++) begin
        s4_x_r[i] <= s4_x_nxt[i];
      end
      s5_dot_r <= s5_dot_nxt;
      for (int i = 0; i < 3; i++) begin
        s5_h_r[i] <= s5_h_nxt[i];
      end
      for (int k = 0; k < NAC; k++) begin
        ac_n_r[k]  <= ac_n_nxt[k];
        ac_rt_r[k] <= ac_rt_nxt[k];
        ac_p_r[k]  <= ac_p_nxt[k];
        ac_x_r[k]  <= src_x[k];
      end
      ac_neg_r[0] <= s5_dot_r[DW-1];
      for (int i = 0; i < 3; i++) begin
        ac_h_r[0][i] <= s5_h_r[i];
      end
      for (int k = 1; k < NAC; k++) begin
        ac_neg_r[k] <= ac_neg_r[k-1];
        for (int i = 0; i < 3; i++) begin
          ac_h_r[k][i] <= ac_h_r[k-1][i];
        end
      end
      s7_prod_r  <= s7_prod_nxt;
      s7_neg_r   <= ac_neg_r[NAC-1];
      s8_angle_r <= s8_angle_nxt;
      s8_act_r   <= (s8_angle_nxt >= max_angle_r);
      s8_diff_r  <= s8_diff_nxt;
      s9_gm_r    <= s9_gm_nxt;
      s9_angle_r <= s8_angle_r;
      s9_act_r   <= s8_act_r;
      s9_diff_r  <= s8_diff_r;
      for (int i = 0; i < 3; i++) begin
        s7_h_r[i] <= ac_h_r[NAC-1][i];
        s8_h_r[i] <= s7_h_r[i];
        s9_h_r[i] <= s8_h_r[i];
      end
      out_r <= out_nxt;
    end
  end

  assign out_ch.valid = vld_r[NSTG-1];
  assign out_ch.data  = out_r;

endmodule
